// ----- rtl/mpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpmc_pkg
// Types, codes and helpers for the manual panel mode controller.
// ----------------------------------------------------------------------------
package mpmc_pkg;

   // panel key bitmaps that act
   localparam logic [7:0] KEY_NONE      = 8'd0;
   localparam logic [7:0] KEY_MANUAL    = 8'd2;
   localparam logic [7:0] KEY_STEP      = 8'd3;
   localparam logic [7:0] KEY_FLASH     = 8'd4;
   localparam logic [7:0] KEY_FLASH_ALT = 8'd6;
   localparam logic [7:0] KEY_ALLRED    = 8'd8;
   localparam logic [7:0] KEY_ALLRED_ALT = 8'd10;
   localparam logic [7:0] KEY_NEXT_PH   = 8'd18;
   localparam logic [7:0] KEY_NEXT_DIR  = 8'd34;

   // panel status codes
   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_ALLRED   = 3'd2;
   localparam logic [2:0] ST_FLASH    = 3'd3;
   localparam logic [2:0] ST_NEXT_PH  = 3'd4;
   localparam logic [2:0] ST_NEXT_DIR = 3'd5;
   localparam logic [2:0] ST_STEP     = 3'd6;

   // actions
   localparam logic [3:0] ACT_LOG      = 4'd0;
   localparam logic [3:0] ACT_AUTO_LED = 4'd1;
   localparam logic [3:0] ACT_SWITCH   = 4'd2;
   localparam logic [3:0] ACT_MANUAL   = 4'd3;
   localparam logic [3:0] ACT_STEP     = 4'd4;
   localparam logic [3:0] ACT_NEXT_ST  = 4'd5;
   localparam logic [3:0] ACT_TEMP_PAT = 4'd6;
   localparam logic [3:0] ACT_DIR      = 4'd7;
   localparam logic [3:0] ACT_RESTORE  = 4'd8;
   localparam logic [3:0] ACT_MAX      = ACT_RESTORE;

   // action values
   localparam logic [7:0] LOG_MANUAL_ON  = 8'd0;
   localparam logic [7:0] LOG_MANUAL_OFF = 8'd1;
   localparam logic [7:0] LOG_FLASH      = 8'd2;
   localparam logic [7:0] LOG_FLASH_OFF  = 8'd3;
   localparam logic [7:0] LOG_ALLRED     = 8'd4;
   localparam logic [7:0] LOG_ALLRED_OFF = 8'd5;
   localparam logic [7:0] LOG_STEP       = 8'd6;
   localparam logic [7:0] LED_OFF        = 8'd0;
   localparam logic [7:0] LED_ON         = 8'd1;
   localparam logic [7:0] SW_NORMAL      = 8'd0;
   localparam logic [7:0] SW_ALLRED      = 8'd253;
   localparam logic [7:0] SW_FLASH       = 8'd254;
   localparam logic [7:0] MANUAL_CODE    = 8'd4;
   localparam logic [7:0] VAL_ZERO       = 8'd0;

   localparam logic [1:0] PAT_ZERO = 2'd0;
   localparam logic [1:0] PAT_TEMP = 2'd1;

   localparam int AUTO_RETURN_MINUTES = 10;
   localparam logic [15:0] TIMEOUT_RESET = 16'(AUTO_RETURN_MINUTES * 600);
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;

   localparam int MAX_WORDS = 4;

   typedef struct packed {
      logic [3:0] act;
      logic [7:0] val;
   } act_word_type;

   typedef struct packed {
      act_word_type [MAX_WORDS-1:0] ent;
      logic [2:0]                   cnt;
   } act_list_type;

   // append one word, dropping it when the list is full
   function automatic act_list_type push(act_list_type lst, logic [3:0] act, logic [7:0] val);
      act_list_type r;
      r = lst;
      if (lst.cnt < 3'(MAX_WORDS)) begin
         r.ent[lst.cnt[1:0]].act = act;
         r.ent[lst.cnt[1:0]].val = val;
         r.cnt = lst.cnt + 3'd1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/manual_panel_mode_controller.sv -----
// ----------------------------------------------------------------------------
// manual_panel_mode_controller
// Front-panel key decoder: tracks manual mode and panel status, emits the
// command words that each key reading causes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | tvalid / tready  | tdata: key_code, next_phase_busy, pattern_state
//  rsp     | out | tvalid / tready  | tdata: action, action_value; tlast: last
//  csr     | in  | wr_en            | wr_data: idle_timeout_limit
//
//  A reading is decoded in its accept cycle; its 0..4 words are loaded into a
//  word list and shifted one per cycle, while rsp is not stalled, into the
//  output register. The next reading is taken once the list holds at most its
//  final word and that word moves to the output register; readings without
//  words flow each cycle.
//  Synchronous active-high reset; a stalled rsp side holds the output register.
// ----------------------------------------------------------------------------
module manual_panel_mode_controller #(
   parameter int DIRECTION_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key_code, [8] next_phase_busy, [10:9] pattern_state
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] action, [11:4] action_value
   output logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // idle_timeout_limit
);
   import mpmc_pkg::*;

   logic [15:0] limit_ff;
   logic [7:0]  prev_key_ff;
   logic        manual_ff, disp_manual_ff;
   logic [2:0]  status_ff, disp_status_ff;
   logic [15:0] idle_ff;
   logic [1:0]  dir_ff;

   logic        manual_in, disp_manual_in;
   logic [2:0]  status_in, disp_status_in;
   logic [15:0] idle_in;
   logic [1:0]  dir_in;
   act_list_type lst_in;

   act_list_type lst_ff;
   logic [2:0]   pend_ff;
   logic [1:0]   pos_ff;
   logic         out_vld_ff;
   act_word_type out_word_ff;
   logic         out_last_ff;

   logic [7:0] key;
   logic       busy;
   logic [1:0] pat;
   logic       skip, done;
   logic [1:0] dsel;
   logic       move, accept;

   assign key  = req_tdata[7:0];
   assign busy = req_tdata[8];
   assign pat  = req_tdata[10:9];

   always_comb begin
      manual_in      = manual_ff;
      status_in      = status_ff;
      disp_manual_in = disp_manual_ff;
      disp_status_in = disp_status_ff;
      idle_in        = idle_ff;
      dir_in         = dir_ff;
      lst_in         = '0;
      skip           = 1'b0;
      done           = 1'b0;
      // index below twice the count: one compare and subtract wraps it
      if (int'(dir_ff) >= DIRECTION_COUNT) dsel = dir_ff - 2'(DIRECTION_COUNT);
      else dsel = dir_ff;

      case (key)
         KEY_NONE: begin
            if (prev_key_ff == KEY_MANUAL) begin
               if (manual_in) begin
                  manual_in = 1'b0;
                  status_in = ST_NONE;
                  lst_in = push(lst_in, ACT_AUTO_LED, LED_ON);
                  lst_in = push(lst_in, ACT_LOG, LOG_MANUAL_OFF);
               end
            end else if (prev_key_ff == KEY_FLASH) begin
               status_in = ST_NONE;
               lst_in = push(lst_in, ACT_LOG, LOG_FLASH_OFF);
            end else if (prev_key_ff == KEY_ALLRED) begin
               status_in = ST_NONE;
               lst_in = push(lst_in, ACT_LOG, LOG_ALLRED_OFF);
            end
         end
         KEY_STEP: begin
            if (manual_in) status_in = ST_STEP;
         end
         KEY_MANUAL: begin
            if (prev_key_ff != KEY_NONE) begin
               skip = 1'b1;
            end else begin
               manual_in = 1'b1;
               lst_in = push(lst_in, ACT_AUTO_LED, LED_OFF);
               lst_in = push(lst_in, ACT_LOG, LOG_MANUAL_ON);
            end
         end
         KEY_FLASH: begin
            if (prev_key_ff == KEY_FLASH_ALT) manual_in = 1'b0;
            if (status_in != ST_FLASH) begin
               status_in = ST_FLASH;
               lst_in = push(lst_in, ACT_LOG, LOG_FLASH);
            end
         end
         KEY_ALLRED: begin
            if (prev_key_ff == KEY_ALLRED_ALT) manual_in = 1'b0;
            if (status_in != ST_ALLRED) begin
               status_in = ST_ALLRED;
               lst_in = push(lst_in, ACT_LOG, LOG_ALLRED);
            end
         end
         KEY_NEXT_PH: begin
            if (manual_in) status_in = ST_NEXT_PH;
         end
         KEY_NEXT_DIR: begin
            if (manual_in) status_in = ST_NEXT_DIR;
         end
         default: skip = 1'b1;
      endcase

      if (!skip) begin
         if (status_in == disp_status_ff && manual_in == disp_manual_ff) begin
            if (!manual_in) begin
               done = 1'b1;
            end else begin
               if (idle_in != IDLE_MAX) idle_in = idle_in + 16'd1;
               if (idle_in > limit_ff) begin
                  manual_in = 1'b0;
                  status_in = ST_NONE;
                  idle_in   = '0;
                  lst_in = push(lst_in, ACT_AUTO_LED, LED_ON);
               end
            end
         end else begin
            idle_in = '0;
         end

         if (!done) begin
            if (status_in == ST_ALLRED) begin
               if (disp_status_ff == ST_ALLRED) done = 1'b1;
               else lst_in = push(lst_in, ACT_SWITCH, SW_ALLRED);
            end else if (status_in == ST_FLASH) begin
               if (disp_status_ff == ST_FLASH) done = 1'b1;
               else lst_in = push(lst_in, ACT_SWITCH, SW_FLASH);
            end else if (manual_in) begin
               if (!disp_manual_ff) lst_in = push(lst_in, ACT_MANUAL, MANUAL_CODE);
               if (status_in == ST_STEP) begin
                  lst_in = push(lst_in, ACT_STEP, VAL_ZERO);
                  lst_in = push(lst_in, ACT_LOG, LOG_STEP);
               end else if (status_in == ST_NEXT_PH) begin
                  if (busy) done = 1'b1;
                  else lst_in = push(lst_in, ACT_NEXT_ST, VAL_ZERO);
               end else if (status_in == ST_NEXT_DIR) begin
                  if (pat == PAT_ZERO) lst_in = push(lst_in, ACT_TEMP_PAT, VAL_ZERO);
                  lst_in = push(lst_in, ACT_DIR, {6'd0, dsel});
                  if (int'(dsel) + 1 >= DIRECTION_COUNT) dir_in = 2'd0;
                  else dir_in = dsel + 2'd1;
               end
            end else if (status_in == ST_NONE) begin
               if (pat == PAT_TEMP) lst_in = push(lst_in, ACT_RESTORE, VAL_ZERO);
               lst_in = push(lst_in, ACT_SWITCH, SW_NORMAL);
            end
         end

         // dispatched copies follow only when the dispatch went through
         if (!done) begin
            disp_status_in = status_in;
            disp_manual_in = manual_in;
         end
      end
   end

   assign move       = (pend_ff != 3'd0) && (!out_vld_ff || rsp_tready);
   assign req_tready = (pend_ff == 3'd0) || (pend_ff == 3'd1 && move);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= TIMEOUT_RESET;
         prev_key_ff    <= '0;
         manual_ff      <= 1'b0;
         status_ff      <= ST_NONE;
         disp_manual_ff <= 1'b0;
         disp_status_ff <= ST_NONE;
         idle_ff        <= '0;
         dir_ff         <= '0;
         pend_ff        <= '0;
         pos_ff         <= '0;
         out_vld_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (accept) begin
            prev_key_ff    <= key;
            manual_ff      <= manual_in;
            status_ff      <= status_in;
            disp_manual_ff <= disp_manual_in;
            disp_status_ff <= disp_status_in;
            idle_ff        <= idle_in;
            dir_ff         <= dir_in;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (accept) begin
            pend_ff <= lst_in.cnt;
            pos_ff  <= '0;
         end else if (move) begin
            pend_ff <= pend_ff - 3'd1;
            pos_ff  <= pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) lst_ff <= lst_in;
      if (move) begin
         out_word_ff <= lst_ff.ent[pos_ff];
         out_last_ff <= (pend_ff == 3'd1);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_word_ff.val, out_word_ff.act};
   assign rsp_tlast  = out_last_ff;

   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'(MAX_WORDS))
      else $error("word list count out of range");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      int'(dir_ff) < DIRECTION_COUNT)
      else $error("direction index beyond count");

   a_act_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_word_ff.act <= ACT_MAX)
      else $error("undefined action code");

   a_load: assert property (@(posedge clock) disable iff (reset)
      (accept && lst_in.cnt != 3'd0) |=> (pend_ff != 3'd0 && pos_ff == 2'd0))
      else $error("word list not loaded after accept");

endmodule
